>>> sv/c2s_pkg.sv
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared constants and the pipeline item type of the cube-to-sphere mapper.
// ----------------------------------------------------------------------------
package c2s_pkg;

    // Internal direction format and normal format
    localparam int WORK_FRAC     = 20;
    localparam int NORM_FRAC     = 14;
    localparam int COORD_FRAC_DEF = 14;

    // floor(p/3) == (p * RECIP3) >> 21 for p <= 2^20
    localparam logic [19:0] RECIP3 = 20'd699051;

    // Step counts of the square-root and divider chains
    localparam int SQRT_STEPS = 21;
    localparam int DIVA_STEPS = 21;
    localparam int DIVB_STEPS = 15;

    // Stage map
    localparam int S_IN   = 0;
    localparam int S_SQ   = 1;
    localparam int S_RCP  = 2;
    localparam int S_QQ   = 3;
    localparam int S_RAD  = 4;
    localparam int S_SQA  = 5;
    localparam int S_DA0  = S_SQA + SQRT_STEPS;
    localparam int S_DVA  = S_DA0 + 1;
    localparam int S_POS0 = S_DVA + DIVA_STEPS;
    localparam int S_POS1 = S_POS0 + 1;
    localparam int S_SQB  = S_POS1 + 1;
    localparam int S_DB0  = S_SQB + SQRT_STEPS;
    localparam int S_DVB  = S_DB0 + 1;
    localparam int S_OUT  = S_DVB + DIVB_STEPS;
    localparam int NUM_STAGES = S_OUT + 1;

    // Register indexes
    localparam logic [2:0] REG_CENTER_X   = 3'd0;
    localparam logic [2:0] REG_CENTER_Y   = 3'd1;
    localparam logic [2:0] REG_CENTER_Z   = 3'd2;
    localparam logic [2:0] REG_RADIUS     = 3'd3;
    localparam logic [2:0] REG_SPHERIFY   = 3'd4;
    localparam logic [2:0] REG_NORMAL_EN  = 3'd5;
    localparam logic [2:0] REG_SMOOTH     = 3'd6;

    // One vertex in flight
    typedef struct packed {
        logic [2:0]        neg;
        logic [2:0][20:0]  mag;
        logic [2:0][40:0]  sq;
        logic [2:0][20:0]  p;
        logic [2:0][19:0]  q;
        logic [2:0][1:0]   rr;
        logic [2:0][38:0]  qq;
        logic [2:0][40:0]  half;
        logic [41:0]       sum;
        logic [2:0][41:0]  acc;
        logic [2:0][41:0]  root;
        logic [20:0]       dvs;
        logic              lenz;
        logic [2:0][20:0]  quo;
        logic [2:0][20:0]  dir;
        logic [2:0][32:0]  pm;
        logic [2:0][31:0]  pos;
        logic              sat;
        logic [2:0][15:0]  nrm;
    } pipe_t;

endpackage

>>> sv/cube_to_sphere_vertex_map.sv
// ----------------------------------------------------------------------------
// cube_to_sphere_vertex_map
// Maps a cube vertex onto a sphere (spherify or normalize), scales, offsets
// and gives the smooth unit normal.
// ----------------------------------------------------------------------------
// One vertex enters per cycle while the pipeline advances; its result passes
// 88 register stages (c2s_pkg::NUM_STAGES). The depth is set by two chains of
// 21 one-bit square-root steps, a 21-step restoring divider for normalize
// mode and a 15-step divider for the normal, each step a register stage.
// When the result register is full and m_ready is low the whole pipeline
// holds; otherwise s_ready stays high. Configuration is written through a
// plain write port and must only change while no vertex is in flight.
module cube_to_sphere_vertex_map #(
    parameter int COORD_FRAC_BITS = c2s_pkg::COORD_FRAC_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write port
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_cube_x,
    input  logic signed [15:0] s_cube_y,
    input  logic signed [15:0] s_cube_z,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_sphere_x,
    output logic signed [31:0] m_sphere_y,
    output logic signed [31:0] m_sphere_z,
    output logic signed [15:0] m_normal_x,
    output logic signed [15:0] m_normal_y,
    output logic signed [15:0] m_normal_z,
    output logic               m_normal_valid,
    output logic               m_saturated
);

    localparam int NST = c2s_pkg::NUM_STAGES;
    localparam int WF  = c2s_pkg::WORK_FRAC;
    localparam logic signed [23:0] ONE_Q = 24'sd1 <<< COORD_FRAC_BITS;
    localparam logic [42:0] ONE40 = 43'd1 << (2 * WF);

    // Configuration registers
    logic signed [31:0] center_x_reg, center_y_reg, center_z_reg;
    logic [31:0]        radius_reg;
    logic               spherify_reg, normal_en_reg, smooth_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            center_z_reg  <= '0;
            radius_reg    <= 32'd65536;
            spherify_reg  <= 1'b1;
            normal_en_reg <= 1'b1;
            smooth_reg    <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                c2s_pkg::REG_CENTER_X:  center_x_reg  <= cfg_wdata;
                c2s_pkg::REG_CENTER_Y:  center_y_reg  <= cfg_wdata;
                c2s_pkg::REG_CENTER_Z:  center_z_reg  <= cfg_wdata;
                c2s_pkg::REG_RADIUS:    radius_reg    <= cfg_wdata;
                c2s_pkg::REG_SPHERIFY:  spherify_reg  <= cfg_wdata[0];
                c2s_pkg::REG_NORMAL_EN: normal_en_reg <= cfg_wdata[0];
                c2s_pkg::REG_SMOOTH:    smooth_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic [2:0][31:0] center_v;
    assign center_v = {center_z_reg, center_y_reg, center_x_reg};

    logic [2:0][15:0] cube_v;
    assign cube_v = {s_cube_z, s_cube_y, s_cube_x};

    // Pipeline storage
    c2s_pkg::pipe_t st_reg  [NST];
    c2s_pkg::pipe_t st_next [NST];
    logic [NST-1:0] vld_reg;
    logic           adv;

    // Global advance: move unless the result register is full and stalled
    assign adv     = !vld_reg[NST-1] || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg <= st_next;
        end
    end

    // Stage logic
    for (genvar k = 0; k < NST; k++) begin : g_st
        if (k == c2s_pkg::S_IN) begin : g_in
            // clamp to +-1.0 and move to Q20 magnitude
            always_comb begin
                logic signed [23:0] v;
                logic [23:0]        a;
                st_next[k] = '0;
                for (int i = 0; i < 3; i++) begin
                    v = {{8{cube_v[i][15]}}, cube_v[i]};
                    if (v > ONE_Q) begin
                        v = ONE_Q;
                    end else if (v < -ONE_Q) begin
                        v = -ONE_Q;
                    end
                    a = v[23] ? 24'(-v) : 24'(v);
                    st_next[k].neg[i] = v[23];
                    st_next[k].mag[i] = 21'(a << (WF - COORD_FRAC_BITS));
                end
            end
        end else if (k == c2s_pkg::S_SQ) begin : g_sq
            // squares and cross products
            always_comb begin
                logic [41:0] pr;
                int          nb, nc;
                st_next[k] = st_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    nb = (i == 2) ? 0 : i + 1;
                    nc = (i == 0) ? 2 : i - 1;
                    st_next[k].sq[i] = 41'(42'(st_reg[k-1].mag[i]) * 42'(st_reg[k-1].mag[i]));
                    pr = 42'(st_reg[k-1].mag[nb]) * 42'(st_reg[k-1].mag[nc]);
                    st_next[k].p[i] = 21'(pr >> WF);
                end
            end
        end else if (k == c2s_pkg::S_RCP) begin : g_rcp
            // p/3 by reciprocal, half sums, length sum
            always_comb begin
                logic [40:0] qm;
                int          nb, nc;
                st_next[k] = st_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    nb = (i == 2) ? 0 : i + 1;
                    nc = (i == 0) ? 2 : i - 1;
                    qm = 41'(st_reg[k-1].p[i]) * 41'(c2s_pkg::RECIP3);
                    st_next[k].q[i]    = qm[40:21];
                    st_next[k].half[i] = 41'((42'(st_reg[k-1].sq[nb])
                                            + 42'(st_reg[k-1].sq[nc])) >> 1);
                end
                st_next[k].sum = 42'(st_reg[k-1].sq[0]) + 42'(st_reg[k-1].sq[1])
                               + 42'(st_reg[k-1].sq[2]);
            end
        end else if (k == c2s_pkg::S_QQ) begin : g_qq
            // q^2 and remainder of p/3
            always_comb begin
                logic [20:0] rem;
                st_next[k] = st_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    st_next[k].qq[i] = 39'(st_reg[k-1].q[i]) * 39'(st_reg[k-1].q[i]);
                    rem = st_reg[k-1].p[i] - 21'(st_reg[k-1].q[i]) * 21'd3;
                    st_next[k].rr[i] = rem[1:0];
                end
            end
        end else if (k == c2s_pkg::S_RAD) begin : g_rad
            // radicand: 1 + p^2/3 - (b^2+c^2)/2, or the length sum
            always_comb begin
                logic [42:0] t;
                logic [42:0] lin;
                logic [42:0] hi;
                logic [41:0] rad;
                st_next[k] = st_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    case (st_reg[k-1].rr[i])
                        2'd1:    lin = 43'(st_reg[k-1].q[i]) << 1;
                        2'd2:    lin = (43'(st_reg[k-1].q[i]) << 2) + 43'd1;
                        default: lin = '0;
                    endcase
                    t  = 43'(st_reg[k-1].qq[i]) * 43'd3 + lin;
                    hi = ONE40 + t;
                    if (hi < 43'(st_reg[k-1].half[i])) begin
                        rad = '0;
                    end else begin
                        rad = 42'(hi - 43'(st_reg[k-1].half[i]));
                    end
                    if (spherify_reg) begin
                        st_next[k].acc[i] = rad;
                    end else begin
                        st_next[k].acc[i] = (i == 0) ? st_reg[k-1].sum : '0;
                    end
                    st_next[k].root[i] = '0;
                end
            end
        end else if ((k >= c2s_pkg::S_SQA && k < c2s_pkg::S_SQA + c2s_pkg::SQRT_STEPS) ||
                     (k >= c2s_pkg::S_SQB && k < c2s_pkg::S_SQB + c2s_pkg::SQRT_STEPS))
        begin : g_sqrt
            localparam int J = (k >= c2s_pkg::S_SQB) ? k - c2s_pkg::S_SQB
                                                     : k - c2s_pkg::S_SQA;
            localparam logic [41:0] BIT = 42'd1 << (40 - 2 * J);
            // one digit of the integer square root
            always_comb begin
                logic [41:0] rb;
                st_next[k] = st_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    rb = st_reg[k-1].root[i] + BIT;
                    if (st_reg[k-1].acc[i] >= rb) begin
                        st_next[k].acc[i]  = st_reg[k-1].acc[i] - rb;
                        st_next[k].root[i] = (st_reg[k-1].root[i] >> 1) + BIT;
                    end else begin
                        st_next[k].root[i] = st_reg[k-1].root[i] >> 1;
                    end
                end
            end
        end else if (k == c2s_pkg::S_DA0) begin : g_da0
            // spherify product; set up normalize divide
            always_comb begin
                logic [41:0] pr;
                st_next[k] = st_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    pr = 42'(st_reg[k-1].mag[i]) * 42'(st_reg[k-1].root[i][20:0]);
                    st_next[k].dir[i] = 21'(pr >> WF);
                    st_next[k].acc[i] = 42'(st_reg[k-1].mag[i]) << WF;
                    st_next[k].quo[i] = '0;
                end
                st_next[k].dvs  = st_reg[k-1].root[0][20:0];
                st_next[k].lenz = (st_reg[k-1].root[0] == '0);
            end
        end else if ((k >= c2s_pkg::S_DVA && k < c2s_pkg::S_DVA + c2s_pkg::DIVA_STEPS) ||
                     (k >= c2s_pkg::S_DVB && k < c2s_pkg::S_DVB + c2s_pkg::DIVB_STEPS))
        begin : g_div
            localparam int QB = (k >= c2s_pkg::S_DVB)
                              ? c2s_pkg::DIVB_STEPS - 1 - (k - c2s_pkg::S_DVB)
                              : c2s_pkg::DIVA_STEPS - 1 - (k - c2s_pkg::S_DVA);
            // one quotient bit of the restoring divider
            always_comb begin
                logic [41:0] ds;
                st_next[k] = st_reg[k-1];
                ds = 42'(st_reg[k-1].dvs) << QB;
                for (int i = 0; i < 3; i++) begin
                    if (st_reg[k-1].acc[i] >= ds) begin
                        st_next[k].acc[i]     = st_reg[k-1].acc[i] - ds;
                        st_next[k].quo[i][QB] = 1'b1;
                    end
                end
            end
        end else if (k == c2s_pkg::S_POS0) begin : g_pos0
            // pick direction, scale by radius, square for normal length
            always_comb begin
                logic [20:0] d;
                logic [52:0] pr;
                st_next[k] = st_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    if (spherify_reg) begin
                        d = st_reg[k-1].dir[i];
                    end else begin
                        d = st_reg[k-1].lenz ? '0 : st_reg[k-1].quo[i];
                    end
                    st_next[k].dir[i] = d;
                    pr = 53'(d) * 53'(radius_reg);
                    st_next[k].pm[i] = 33'(pr >> WF);
                    st_next[k].sq[i] = 41'(42'(d) * 42'(d));
                end
            end
        end else if (k == c2s_pkg::S_POS1) begin : g_pos1
            // offset by center with saturation; normal length radicand
            always_comb begin
                logic signed [34:0] c;
                logic signed [34:0] m;
                logic signed [34:0] t;
                st_next[k] = st_reg[k-1];
                st_next[k].sat = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    c = {{3{center_v[i][31]}}, center_v[i]};
                    m = {2'b00, st_reg[k-1].pm[i]};
                    t = st_reg[k-1].neg[i] ? c - m : c + m;
                    if (t > 35'sh07FFFFFFF) begin
                        st_next[k].pos[i] = 32'h7FFFFFFF;
                        st_next[k].sat    = 1'b1;
                    end else if (t < -35'sh080000000) begin
                        st_next[k].pos[i] = 32'h80000000;
                        st_next[k].sat    = 1'b1;
                    end else begin
                        st_next[k].pos[i] = t[31:0];
                    end
                    st_next[k].acc[i]  = '0;
                    st_next[k].root[i] = '0;
                end
                st_next[k].acc[0] = 42'(st_reg[k-1].sq[0]) + 42'(st_reg[k-1].sq[1])
                                  + 42'(st_reg[k-1].sq[2]);
            end
        end else if (k == c2s_pkg::S_DB0) begin : g_db0
            // set up normal divide
            always_comb begin
                st_next[k] = st_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    st_next[k].acc[i] = 42'(st_reg[k-1].dir[i]) << c2s_pkg::NORM_FRAC;
                    st_next[k].quo[i] = '0;
                end
                st_next[k].dvs  = st_reg[k-1].root[0][20:0];
                st_next[k].lenz = (st_reg[k-1].root[0] == '0);
            end
        end else begin : g_out
            // signed normal, gated by enables
            always_comb begin
                logic [15:0] n;
                st_next[k] = st_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    n = st_reg[k-1].quo[i][15:0];
                    if (!(normal_en_reg && smooth_reg) || st_reg[k-1].lenz) begin
                        st_next[k].nrm[i] = '0;
                    end else begin
                        st_next[k].nrm[i] = st_reg[k-1].neg[i] ? 16'(-n) : n;
                    end
                end
            end
        end
    end

    // Result outputs
    assign m_valid        = vld_reg[NST-1];
    assign m_sphere_x     = st_reg[NST-1].pos[0];
    assign m_sphere_y     = st_reg[NST-1].pos[1];
    assign m_sphere_z     = st_reg[NST-1].pos[2];
    assign m_normal_x     = st_reg[NST-1].nrm[0];
    assign m_normal_y     = st_reg[NST-1].nrm[1];
    assign m_normal_z     = st_reg[NST-1].nrm[2];
    assign m_normal_valid = normal_en_reg && smooth_reg;
    assign m_saturated    = st_reg[NST-1].sat;

    // Checks
    a_norm_off_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_normal_valid |-> m_normal_x == 16'sd0 && m_normal_y == 16'sd0
                                       && m_normal_z == 16'sd0)
        else $error("normal not zero while disabled");

    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_normal_x <= 16'sd16384 && m_normal_x >= -16'sd16384
                 && m_normal_y <= 16'sd16384 && m_normal_y >= -16'sd16384
                 && m_normal_z <= 16'sd16384 && m_normal_z >= -16'sd16384)
        else $error("normal component beyond unit");

    a_sat_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            m_sphere_x == 32'sh7FFFFFFF || m_sphere_x == -32'sh80000000 ||
            m_sphere_y == 32'sh7FFFFFFF || m_sphere_y == -32'sh80000000 ||
            m_sphere_z == 32'sh7FFFFFFF || m_sphere_z == -32'sh80000000)
        else $error("saturated flag without clamped component");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

endmodule

>>> tb/cube_to_sphere_vertex_map_tb.sv
// ----------------------------------------------------------------------------
// cube_to_sphere_vertex_map_tb
// Drives cube vertices with random gaps and back-pressure, predicts each
// mapped position and normal in SystemVerilog, and compares every result
// transfer in order. Several register settings are exercised between phases.
// ----------------------------------------------------------------------------
module cube_to_sphere_vertex_map_tb;

    localparam int PIPE_DRAIN = c2s_pkg::NUM_STAGES + 10;

    // Expected result of one vertex
    typedef struct packed {
        logic [31:0] px, py, pz;
        logic [15:0] nx, ny, nz;
        logic        nvld;
        logic        sat;
    } vtx_res_t;

    // Directed stimulus row; chk set when the result is typed in
    typedef struct {
        logic [15:0] x, y, z;
        bit          chk;
        vtx_res_t    res;
    } vtx_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic signed [15:0] s_cube_x, s_cube_y, s_cube_z;
    logic        m_valid;
    logic        m_ready;
    logic signed [31:0] m_sphere_x, m_sphere_y, m_sphere_z;
    logic signed [15:0] m_normal_x, m_normal_y, m_normal_z;
    logic        m_normal_valid;
    logic        m_saturated;

    // Shadow copy of the register file
    logic signed [31:0] ctr_x, ctr_y, ctr_z;
    logic [31:0] radius;
    logic        spherify, nrm_en, smooth;

    vtx_res_t    pending_q[$];
    int          errors;
    bit          stall_long;
    bit          rx_quiet;

    cube_to_sphere_vertex_map dut (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [63:0] isqrt(logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // sqrt(1 - (b^2+c^2)/2 + (bc)^2/3) in Q20
    function automatic logic [63:0] squeeze(logic [63:0] mb, logic [63:0] mc);
        logic [63:0] p;
        longint s;
        p = (mb * mc) >> 20;
        s = (longint'(1) << 40) + longint'((p * p) / 3) - longint'((mb * mb + mc * mc) >> 1);
        if (s < 0) s = 0;
        return isqrt(s);
    endfunction

    function automatic logic [31:0] place(bit neg, logic [63:0] mag,
                                          logic signed [31:0] c, inout logic sat);
        longint m, t;
        m = longint'((mag * {32'd0, radius}) >> 20);
        t = longint'(c) + (neg ? -m : m);
        if (t > 64'sd2147483647) begin
            t = 64'sd2147483647; sat = 1'b1;
        end else if (t < -64'sd2147483648) begin
            t = -64'sd2147483648; sat = 1'b1;
        end
        return t[31:0];
    endfunction

    function automatic vtx_res_t map_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        vtx_res_t r;
        logic [15:0] raw[3];
        logic [63:0] mag[3], dir[3], len;
        bit neg[3];
        int v;
        longint n;
        logic [15:0] nn[3];
        raw[0] = x; raw[1] = y; raw[2] = z;
        for (int i = 0; i < 3; i++) begin
            v = $signed(raw[i]);
            if (v > 16384) v = 16384;
            if (v < -16384) v = -16384;
            neg[i] = v < 0;
            mag[i] = 64'(v < 0 ? -v : v) << 6;
        end
        if (spherify) begin
            for (int i = 0; i < 3; i++)
                dir[i] = (mag[i] * squeeze(mag[(i + 1) % 3], mag[(i + 2) % 3])) >> 20;
        end else begin
            len = isqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
            for (int i = 0; i < 3; i++)
                dir[i] = (len != 0) ? (mag[i] << 20) / len : 0;
        end
        r.sat = 1'b0;
        r.px = place(neg[0], dir[0], ctr_x, r.sat);
        r.py = place(neg[1], dir[1], ctr_y, r.sat);
        r.pz = place(neg[2], dir[2], ctr_z, r.sat);
        if (nrm_en && smooth) begin
            len = isqrt(dir[0] * dir[0] + dir[1] * dir[1] + dir[2] * dir[2]);
            for (int i = 0; i < 3; i++) begin
                n = (len != 0) ? longint'((dir[i] << 14) / len) : 0;
                if (neg[i]) n = -n;
                nn[i] = n[15:0];
            end
            r.nvld = 1'b1;
        end else begin
            nn[0] = 0; nn[1] = 0; nn[2] = 0;
            r.nvld = 1'b0;
        end
        r.nx = nn[0]; r.ny = nn[1]; r.nz = nn[2];
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            c2s_pkg::REG_CENTER_X:  ctr_x = val;
            c2s_pkg::REG_CENTER_Y:  ctr_y = val;
            c2s_pkg::REG_CENTER_Z:  ctr_z = val;
            c2s_pkg::REG_RADIUS:    radius = val;
            c2s_pkg::REG_SPHERIFY:  spherify = val[0];
            c2s_pkg::REG_NORMAL_EN: nrm_en = val[0];
            c2s_pkg::REG_SMOOTH:    smooth = val[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    endfunction

    // One vertex transfer, with a random idle gap first when idle is set
    task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z, bit idle);
        int g;
        g = idle ? gap_len() : 0;
        if (g != 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_cube_x <= x;
        s_cube_y <= y;
        s_cube_z <= z;
        do @(posedge aclk); while (!s_ready);
        pending_q.push_back(map_vertex(x, y, z));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'd0;
            3: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [15:0] x, y, z;
        for (int k = 0; k < count; k++) begin
            x = rand_coord(); y = rand_coord(); z = rand_coord();
            // mostly a surface point of the cube: one axis pinned to a face
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 2))
                    0: x = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
                    1: y = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
                    default: z = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
                endcase
            end
            send_vertex(x, y, z, !rx_quiet && (k % 100) < 70);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int g;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (stall_long) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                stall_long = 1'b0;
            end
            g = rx_quiet ? 0 : gap_len();
            if (g != 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        vtx_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result transfer", $time);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if ({m_sphere_x, m_sphere_y, m_sphere_z, m_normal_x, m_normal_y, m_normal_z,
                     m_normal_valid, m_saturated} !==
                    {e.px, e.py, e.pz, e.nx, e.ny, e.nz, e.nvld, e.sat}) begin
                    $display("%0t: mismatch exp pos %h %h %h nrm %h %h %h nv %b sat %b",
                             $time, e.px, e.py, e.pz, e.nx, e.ny, e.nz, e.nvld, e.sat);
                    $display("%0t:          act pos %h %h %h nrm %h %h %h nv %b sat %b",
                             $time, m_sphere_x, m_sphere_y, m_sphere_z, m_normal_x,
                             m_normal_y, m_normal_z, m_normal_valid, m_saturated);
                    errors++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        vtx_row_t rows[$];
        vtx_row_t row;
        vtx_res_t got;
        errors     = 0;
        stall_long = 1'b0;
        rx_quiet   = 1'b0;
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = c2s_pkg::REG_CENTER_X;
        cfg_wdata  = 32'd0;
        s_valid    = 1'b0;
        s_cube_x   = 16'd0;
        s_cube_y   = 16'd0;
        s_cube_z   = 16'd0;
        ctr_x = 0; ctr_y = 0; ctr_z = 0;
        radius = 32'd65536; spherify = 1'b1; nrm_en = 1'b1; smooth = 1'b1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset settings; axis points are read off directly
        rows = '{
            '{16'sd16384, 16'd0, 16'd0, 1'b1,
              '{32'h0001_0000, 0, 0, 16'sd16384, 0, 0, 1'b1, 1'b0}},
            '{-16'sd16384, 16'd0, 16'd0, 1'b1,
              '{32'hFFFF_0000, 0, 0, -16'sd16384, 0, 0, 1'b1, 1'b0}},
            '{16'd0, 16'sd16384, 16'd0, 1'b1,
              '{0, 32'h0001_0000, 0, 0, 16'sd16384, 0, 1'b1, 1'b0}},
            '{16'd0, 16'd0, 16'sh7FFF, 1'b1,
              '{0, 0, 32'h0001_0000, 0, 0, 16'sd16384, 1'b1, 1'b0}},
            '{16'd0, 16'd0, 16'd0, 1'b1, '{0, 0, 0, 0, 0, 0, 1'b1, 1'b0}},
            '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '{default: 0}},
            '{16'sd16384, 16'sd16384, 16'sd16384, 1'b0, '{default: 0}},
            '{16'sd16384, -16'sd8192, 16'sd1, 1'b0, '{default: 0}},
            '{16'sd100, 16'sd16383, -16'sd16383, 1'b0, '{default: 0}},
            '{16'hFFFF, 16'h5555, 16'hAAAA, 1'b0, '{default: 0}}
        };
        foreach (rows[i]) begin
            row = rows[i];
            send_vertex(row.x, row.y, row.z, 1'b1);
            if (row.chk) begin
                got = pending_q[$];
                if (got != row.res) begin
                    $display("%0t: directed row %0d predictor disagrees with table",
                             $time, i);
                    errors++;
                end
                pending_q[$] = row.res;
            end
        end
        drain();

        // Normalize mode, large radius and extreme centers: saturation
        write_reg(c2s_pkg::REG_SPHERIFY, 32'd0);
        write_reg(c2s_pkg::REG_RADIUS, 32'hFFFF_FFFF);
        write_reg(c2s_pkg::REG_CENTER_X, 32'h7FFF_FFFF);
        write_reg(c2s_pkg::REG_CENTER_Y, 32'h8000_0000);
        write_reg(c2s_pkg::REG_CENTER_Z, 32'h1234_5678);
        send_vertex(16'd0, 16'd0, 16'd0, 1'b0);
        send_vertex(16'sd16384, -16'sd16384, 16'sd16384, 1'b0);
        send_vertex(-16'sd16384, 16'sd16384, -16'sd16384, 1'b0);
        random_phase(150);
        drain();

        // Zero radius, normals off; long receiver hold-off with no idling
        write_reg(c2s_pkg::REG_RADIUS, 32'd0);
        write_reg(c2s_pkg::REG_NORMAL_EN, 32'd0);
        write_reg(c2s_pkg::REG_SPHERIFY, 32'd1);
        rx_quiet   = 1'b1;
        stall_long = 1'b1;
        random_phase(150);
        rx_quiet = 1'b0;
        drain();

        // Flat normals, random centers and radius
        write_reg(c2s_pkg::REG_NORMAL_EN, 32'd1);
        write_reg(c2s_pkg::REG_SMOOTH, 32'd0);
        write_reg(c2s_pkg::REG_CENTER_X, $urandom);
        write_reg(c2s_pkg::REG_CENTER_Y, $urandom);
        write_reg(c2s_pkg::REG_CENTER_Z, $urandom);
        write_reg(c2s_pkg::REG_RADIUS, $urandom);
        random_phase(150);
        drain();

        // Smooth normals back on: spherify with a moderate radius, then normalize
        write_reg(c2s_pkg::REG_SMOOTH, 32'd1);
        write_reg(c2s_pkg::REG_RADIUS, $urandom_range(0, 32'h00FF_FFFF));
        random_phase(150);
        drain();
        write_reg(c2s_pkg::REG_SPHERIFY, 32'd0);
        write_reg(c2s_pkg::REG_CENTER_X, 32'h8000_0000);
        write_reg(c2s_pkg::REG_CENTER_Y, 32'h7FFF_FFFF);
        write_reg(c2s_pkg::REG_RADIUS, 32'h8000_0000);
        random_phase(150);
        drain();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
